// ----- rtl/core/pps_pkg.sv -----
// Shared constants, beat types and the slot table entry for the priority scheduler.
package pps_pkg;

  localparam int MAX_PROCS = 8;
  localparam int TIME_BITS = 16;
  localparam int IDX_BITS  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int SLOT_W    = 3;
  localparam int FIELD_W   = 16;
  localparam int PRIO_W    = 8;
  localparam int CMP_BITS  = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [SLOT_W-1:0]   slot;
    logic [FIELD_W-1:0]  arrival_time;
    logic [FIELD_W-1:0]  burst_length;
    logic [PRIO_W-1:0]   priority_level;
  } cmd_t;

  typedef struct packed {
    logic                idle;
    logic [SLOT_W-1:0]   chosen_slot;
    logic                finished;
    logic [FIELD_W-1:0]  completion_time;
    logic [FIELD_W-1:0]  turnaround_time;
    logic [FIELD_W-1:0]  waiting_time;
    logic                all_done;
  } res_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] arrival;
    logic [FIELD_W-1:0]   remaining;
    logic [FIELD_W-1:0]   burst;
    logic [PRIO_W-1:0]    prio;
  } entry_t;

  // read beat coming back from the slot table
  typedef struct packed {
    logic                vld;
    logic [IDX_BITS-1:0] idx;
  } scan_t;

endpackage

// ----- rtl/core/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler: slot table in a synchronous memory, scanned once per tick.
//
//   channel | valid     | stall     | payload | beat
//   command | cmd_valid | cmd_stall | cmd     | load one slot, or advance one tick
//   result  | res_valid | res_stall | res     | one per tick, none per load
//
// A load writes its slot as soon as it is accepted. On a tick the single
// read port of the slot table walks every slot, one read a cycle with the read data
// registered, then the calc step writes the chosen slot back and the emit step moves the result out.
// Reset clears the loaded and finished masks and the time; table contents need none.
// A stalled result does not block further loads; the next tick waits in the last step.
module preemptive_priority_scheduler import pps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_EMIT
  } state_t;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_PROCS - 1);

  state_t                 state;
  entry_t                 mem [MAX_PROCS];
  entry_t                 rd_data;
  logic                   rd_en;
  logic [IDX_BITS-1:0]    rd_addr;
  scan_t                  rd_beat;
  logic                   wr_en;
  logic [IDX_BITS-1:0]    wr_addr;
  entry_t                 wr_data;
  logic [MAX_PROCS-1:0]   loaded_mask;
  logic [MAX_PROCS-1:0]   done_mask;
  logic [TIME_BITS-1:0]   cur_time;
  logic                   found;
  logic [IDX_BITS-1:0]    best_idx;
  entry_t                 best;
  logic                   r_idle;
  logic [SLOT_W-1:0]      r_slot;
  logic                   r_fin;
  logic [TIME_BITS-1:0]   r_comp;
  logic [TIME_BITS-1:0]   r_turn;

  logic                   cmd_acc;
  logic                   tick_start;
  logic                   load_ok;
  logic [IDX_BITS-1:0]    ld_idx;
  logic [FIELD_W-1:0]     rem_dec;
  logic [TIME_BITS-1:0]   time_inc;
  logic [TIME_BITS-1:0]   turn_calc;
  logic [CMP_BITS-1:0]    wait_calc;

  assign cmd_stall  = (state != ST_IDLE);
  assign cmd_acc    = cmd_valid && !cmd_stall;
  assign tick_start = cmd_acc && (cmd.operation == OP_TICK);
  assign load_ok    = (int'(cmd.slot) < MAX_PROCS);
  assign ld_idx     = IDX_BITS'(cmd.slot);
  assign rem_dec    = best.remaining - FIELD_W'(1);
  assign time_inc   = (cur_time == '1) ? cur_time : cur_time + TIME_BITS'(1);
  assign turn_calc  = time_inc - best.arrival;

  // waiting time floors at zero
  always_comb begin
    if (CMP_BITS'(r_turn) > CMP_BITS'(best.burst)) begin
      wait_calc = CMP_BITS'(r_turn) - CMP_BITS'(best.burst);
    end else begin
      wait_calc = '0;
    end
  end

  always_comb begin
    wr_en             = 1'b0;
    wr_addr           = best_idx;
    wr_data           = best;
    wr_data.remaining = rem_dec;
    if (cmd_acc && (cmd.operation == OP_LOAD) && load_ok) begin
      wr_en   = 1'b1;
      wr_addr = ld_idx;
      wr_data = '{arrival:   TIME_BITS'(cmd.arrival_time),
                  remaining: cmd.burst_length,
                  burst:     cmd.burst_length,
                  prio:      cmd.priority_level};
    end else if ((state == ST_CALC) && found) begin
      wr_en = 1'b1;
    end
  end

  // slot table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_beat.vld <= 1'b0;
    end else begin
      rd_beat.vld <= rd_en;
    end
    rd_beat.idx <= rd_addr;
  end

  pps_select u_select (
    .clk         (clk),
    .rst         (rst),
    .start       (tick_start),
    .rd_beat     (rd_beat),
    .rd_data     (rd_data),
    .loaded_mask (loaded_mask),
    .done_mask   (done_mask),
    .cur_time    (cur_time),
    .found       (found),
    .best_idx    (best_idx),
    .best        (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rd_en       <= 1'b0;
      rd_addr     <= '0;
      loaded_mask <= '0;
      done_mask   <= '0;
      cur_time    <= '0;
      res_valid   <= 1'b0;
    end else begin
      // the emit step decides valid itself
      if (res_valid && !res_stall && (state != ST_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_acc) begin
            if (cmd.operation == OP_LOAD) begin
              // reload restarts the slot; zero burst loads as already finished
              if (load_ok) begin
                loaded_mask[ld_idx] <= 1'b1;
                done_mask[ld_idx]   <= (cmd.burst_length == '0);
              end
            end else begin
              rd_addr <= '0;
              rd_en   <= 1'b1;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            if (rd_addr == LAST_IDX) begin
              rd_en <= 1'b0;
            end else begin
              rd_addr <= rd_addr + IDX_BITS'(1);
            end
          end
          if (rd_beat.vld && (rd_beat.idx == LAST_IDX)) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          r_idle <= !found;
          r_slot <= found ? SLOT_W'(best_idx) : '0;
          if (found && (rem_dec == '0)) begin
            done_mask[best_idx] <= 1'b1;
            r_fin  <= 1'b1;
            r_comp <= time_inc;
            r_turn <= turn_calc;
          end else begin
            r_fin  <= 1'b0;
            r_comp <= '0;
            r_turn <= '0;
          end
          cur_time <= time_inc;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res_valid || !res_stall) begin
            res_valid           <= 1'b1;
            res.idle            <= r_idle;
            res.chosen_slot     <= r_slot;
            res.finished        <= r_fin;
            res.completion_time <= FIELD_W'(r_comp);
            res.turnaround_time <= FIELD_W'(r_turn);
            res.waiting_time    <= r_fin ? FIELD_W'(wait_calc) : '0;
            res.all_done        <= ((loaded_mask & ~done_mask) == '0);
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_loaded: assert property (@(posedge clk) disable iff (rst)
    (done_mask & ~loaded_mask) == '0)
    else $error("finished slot not loaded");

  a_pick_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) && found |->
      loaded_mask[best_idx] && !done_mask[best_idx] && (best.arrival <= cur_time))
    else $error("chosen slot was not ready");

  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    !rst |=> cur_time >= $past(cur_time))
    else $error("time went backwards");

  a_idle_fin: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.idle && res.finished))
    else $error("idle tick reported a completion");
`endif

endmodule

// ----- rtl/core/pps_select.sv -----
// Running best-candidate tracker fed by the slot table read beats.
module pps_select import pps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  scan_t                 rd_beat,
  input  entry_t                rd_data,
  input  logic [MAX_PROCS-1:0]  loaded_mask,
  input  logic [MAX_PROCS-1:0]  done_mask,
  input  logic [TIME_BITS-1:0]  cur_time,
  output logic                  found,
  output logic [IDX_BITS-1:0]   best_idx,
  output entry_t                best
);

  logic take;

  // strict less-than keeps the lower index on equal priority
  always_comb begin
    take = rd_beat.vld && loaded_mask[rd_beat.idx] && !done_mask[rd_beat.idx] &&
           (rd_data.arrival <= cur_time) && (!found || (rd_data.prio < best.prio));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
    if (take) begin
      best_idx <= rd_beat.idx;
      best     <= rd_data;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the preemptive priority scheduler: directed and random runs.
module tb_top;
  import pps_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_TOP = '1;
  localparam int TAIL_CYCLES = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  preemptive_priority_scheduler dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // own copy of the slot table and the scheduler clock
  logic [TIME_BITS-1:0] slot_arrival [MAX_PROCS];
  logic [FIELD_W-1:0]   slot_left    [MAX_PROCS];
  logic [FIELD_W-1:0]   slot_burst   [MAX_PROCS];
  logic [PRIO_W-1:0]    slot_prio    [MAX_PROCS];
  logic [MAX_PROCS-1:0] slot_loaded = '0;
  logic [TIME_BITS-1:0] sched_now = '0;
  int done_slots = 0;
  int loaded_slots = 0;

  res_t expected_ticks [$];
  cmd_t pending_cmds [$];
  res_t want;

  int send_idle_pct = 0;
  int res_stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int ticks_sent = 0;
  int beats_accepted = 0;
  int ticks_checked = 0;
  int finishes_seen = 0;
  int idles_seen = 0;

  // Applies one accepted command beat; a tick queues the result it must produce.
  function automatic void predict_schedule(input cmd_t c);
    int s;
    int i;
    int best;
    logic found;
    logic [TIME_BITS-1:0] comp;
    logic [TIME_BITS-1:0] turn;
    res_t r;
    if (c.operation == OP_LOAD) begin
      s = int'(c.slot);
      if (slot_loaded[s]) begin
        // reloading a finished slot takes it off the done count
        if (slot_left[s] == '0 && done_slots > 0) done_slots--;
      end else begin
        slot_loaded[s] = 1'b1;
        loaded_slots++;
      end
      slot_arrival[s] = TIME_BITS'(c.arrival_time);
      slot_burst[s] = c.burst_length;
      slot_left[s] = c.burst_length;
      slot_prio[s] = c.priority_level;
      if (c.burst_length == '0) done_slots++;
    end else begin
      r = '0;
      found = 1'b0;
      best = 0;
      for (i = 0; i < MAX_PROCS; i++) begin
        if (slot_loaded[i] && slot_arrival[i] <= sched_now && slot_left[i] != '0 &&
            (!found || slot_prio[i] < slot_prio[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      if (found) begin
        slot_left[best] = slot_left[best] - 1'b1;
        r.chosen_slot = SLOT_W'(best);
        if (slot_left[best] == '0) begin
          done_slots++;
          comp = (sched_now < TIME_TOP) ? sched_now + 1'b1 : TIME_TOP;
          turn = comp - slot_arrival[best];
          r.finished = 1'b1;
          r.completion_time = FIELD_W'(comp);
          r.turnaround_time = FIELD_W'(turn);
          r.waiting_time = (turn > slot_burst[best]) ? FIELD_W'(turn - slot_burst[best]) : '0;
        end
      end else begin
        r.idle = 1'b1;
      end
      if (sched_now < TIME_TOP) sched_now = sched_now + 1'b1;
      r.all_done = (done_slots >= loaded_slots);
      expected_ticks.push_back(r);
    end
  endfunction

  // command driver: holds a stalled beat, otherwise takes the next queued one or idles
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        predict_schedule(cmd);
        beats_accepted++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_stall <= !rst && ($urandom_range(99) < res_stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_ticks.size() == 0) begin
        $error("result beat with no tick outstanding");
        mismatches++;
      end else begin
        want = expected_ticks.pop_front();
        ticks_checked++;
        if (want.finished) finishes_seen++;
        if (want.idle) idles_seen++;
        check_field("idle", 32'(want.idle), 32'(res.idle));
        check_field("chosen_slot", 32'(want.chosen_slot), 32'(res.chosen_slot));
        check_field("finished", 32'(want.finished), 32'(res.finished));
        check_field("completion_time", 32'(want.completion_time),
                    32'(res.completion_time));
        check_field("turnaround_time", 32'(want.turnaround_time),
                    32'(res.turnaround_time));
        check_field("waiting_time", 32'(want.waiting_time), 32'(res.waiting_time));
        check_field("all_done", 32'(want.all_done), 32'(res.all_done));
      end
    end
  end

  // queues are filled on the falling edge so the driver never races the test thread
  task automatic send_cmd(input cmd_t c);
    while (pending_cmds.size() >= 2) @(negedge clk);
    pending_cmds.push_back(c);
    items_sent++;
    if (c.operation == OP_TICK) ticks_sent++;
  endtask

  task automatic send_load(input int s, input logic [FIELD_W-1:0] arr,
                           input logic [FIELD_W-1:0] len, input logic [PRIO_W-1:0] prio);
    cmd_t c;
    c.operation = OP_LOAD;
    c.slot = SLOT_W'(s);
    c.arrival_time = arr;
    c.burst_length = len;
    c.priority_level = prio;
    send_cmd(c);
  endtask

  // unused fields of a tick carry noise
  task automatic send_tick();
    cmd_t c;
    c.operation = OP_TICK;
    c.slot = SLOT_W'($urandom_range(7));
    c.arrival_time = FIELD_W'($urandom);
    c.burst_length = FIELD_W'($urandom);
    c.priority_level = PRIO_W'($urandom);
    send_cmd(c);
  endtask

  task automatic wait_drain();
    while (pending_cmds.size() != 0 || cmd_valid || expected_ticks.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    res_stall_pct = 0;
    send_tick();                                // empty table: idle and all done
    send_load(0, 16'd0, 16'd1, 8'hFF);
    send_tick();                                // one beat of work, done at once
    send_load(7, 16'd4, 16'd2, 8'h00);          // not yet arrived
    send_load(3, 16'd0, 16'd0, 8'h00);          // zero burst counts as done on load
    send_tick();
    send_tick();
    send_tick();
    send_load(2, 16'd0, 16'd3, 8'h80);
    send_load(5, 16'd0, 16'd3, 8'h80);          // equal priority, lower index first
    send_tick();
    send_tick();
    send_load(2, 16'd1, 16'd2, 8'h80);          // reload while part run
    send_load(7, 16'hFFFF, 16'hFFFF, 8'h00);    // reload a finished slot, far future
    send_load(1, 16'd5, 16'd1, 8'h7F);          // preempts the pair
    repeat (6) send_tick();
  endtask

  // Mostly short batches of loads near the current time followed by ticks, plus raw noise.
  task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
    int start;
    cmd_t c;
    send_idle_pct = idle_pct;
    res_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(9) == 0) begin
        c.operation = $urandom_range(1) ? OP_TICK : OP_LOAD;
        c.slot = SLOT_W'($urandom_range(7));
        c.arrival_time = FIELD_W'($urandom);
        c.burst_length = ($urandom_range(7) == 0) ? '0 : FIELD_W'($urandom);
        c.priority_level = PRIO_W'($urandom);
        send_cmd(c);
      end else begin
        repeat ($urandom_range(1, 4))
          send_load($urandom_range(7), FIELD_W'(ticks_sent + $urandom_range(6)),
                    FIELD_W'($urandom_range(1, 8)),
                    $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom));
        repeat ($urandom_range(1, 16)) send_tick();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(0, 0, 500);
    test_random(65, 0, 500);
    test_random(0, 65, 500);
    test_random(11, 11, 500);
    wait_drain();
    $display("scheduler: %0d command beats taken, %0d tick results checked",
             beats_accepted, ticks_checked);
    $display("scheduler: %0d completions, %0d idle ticks over directed and random phases",
             finishes_seen, idles_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pps_pkg.sv
rtl/core/pps_select.sv
rtl/core/preemptive_priority_scheduler.sv
tb/sv/tb_top.sv
